/* hw/rtl/planar_map_canonical_code_core_assert.svh */
// Assertion macros used by the checker file of the canonical code core
`ifndef PLANAR_MAP_CANONICAL_CODE_CORE_ASSERT_SVH
`define PLANAR_MAP_CANONICAL_CODE_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define PMCC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define PMCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/pmcc_pkg.sv */
// Shared types and constants of the planar map canonical code core
`default_nettype none

package pmcc_pkg;

   localparam int NODE_W = 6;
   localparam int ARC_W  = 2;
   localparam int ARCS   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_USE_REFLECTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIGHT_MODE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT     = 2'd2;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_PRE,
      ST_SRC,
      ST_OFF,
      ST_ADJ,
      ST_NB,
      ST_CMP,
      ST_TRY_END,
      ST_OUT_RD,
      ST_OUT_CAP,
      ST_OUT_WAIT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_wr;
      logic run_start;
      logic try_init;
      logic pre_rd;
      logic src_sel;
      logic off_load;
      logic adj_rd;
      logic nb_step;
      logic cmp_step;
      logic try_end;
      logic out_rd;
      logic rsp_set;
      logic rsp_clr;
      logic row_next;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic worse;
      logic arc_last;
      logic lab_last;
      logic search_done;
   } status_type;

endpackage

`default_nettype wire

/* hw/rtl/pmcc_ctrl.sv */
// Controller state machine of the canonical code core
`default_nettype none

module pmcc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_kind,
   input  wire logic                rsp_stall,
   input  wire pmcc_pkg::status_type status,
   output logic                     req_stall,
   output pmcc_pkg::cmd_type        cmd
);

   pmcc_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmcc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != pmcc_pkg::ST_IDLE);
      unique case (state_ff)
         pmcc_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == pmcc_pkg::KIND_RUN) begin
                  cmd.run_start = 1'b1;
                  state_in      = pmcc_pkg::ST_INIT;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         pmcc_pkg::ST_INIT: begin
            cmd.try_init = 1'b1;
            state_in     = pmcc_pkg::ST_PRE;
         end
         pmcc_pkg::ST_PRE: begin
            cmd.pre_rd = 1'b1;
            state_in   = pmcc_pkg::ST_SRC;
         end
         pmcc_pkg::ST_SRC: begin
            cmd.src_sel = 1'b1;
            state_in    = pmcc_pkg::ST_OFF;
         end
         pmcc_pkg::ST_OFF: begin
            cmd.off_load = 1'b1;
            state_in     = pmcc_pkg::ST_ADJ;
         end
         pmcc_pkg::ST_ADJ: begin
            cmd.adj_rd = 1'b1;
            state_in   = pmcc_pkg::ST_NB;
         end
         pmcc_pkg::ST_NB: begin
            cmd.nb_step = 1'b1;
            state_in    = pmcc_pkg::ST_CMP;
         end
         pmcc_pkg::ST_CMP: begin
            // drop the try as soon as it loses
            if (status.worse) begin
               state_in = pmcc_pkg::ST_TRY_END;
            end else begin
               cmd.cmp_step = 1'b1;
               if (!status.arc_last) begin
                  state_in = pmcc_pkg::ST_ADJ;
               end else if (status.lab_last) begin
                  state_in = pmcc_pkg::ST_TRY_END;
               end else begin
                  state_in = pmcc_pkg::ST_PRE;
               end
            end
         end
         pmcc_pkg::ST_TRY_END: begin
            cmd.try_end = 1'b1;
            state_in = status.search_done ? pmcc_pkg::ST_OUT_RD : pmcc_pkg::ST_INIT;
         end
         pmcc_pkg::ST_OUT_RD: begin
            cmd.out_rd = 1'b1;
            if (status.arc_last) begin
               state_in = pmcc_pkg::ST_OUT_CAP;
            end
         end
         pmcc_pkg::ST_OUT_CAP: begin
            cmd.rsp_set = 1'b1;
            state_in    = pmcc_pkg::ST_OUT_WAIT;
         end
         pmcc_pkg::ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               cmd.rsp_clr = 1'b1;
               if (status.lab_last) begin
                  state_in = pmcc_pkg::ST_IDLE;
               end else begin
                  cmd.row_next = 1'b1;
                  state_in     = pmcc_pkg::ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = pmcc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/pmcc_dp.sv */
// Datapath of the canonical code core: tables, labeling and code compare
`default_nettype none

module pmcc_dp #(
   parameter int MAX_NODES = 52
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pmcc_pkg::cmd_type                   cmd,
   output pmcc_pkg::status_type                     status,
   input  wire logic                                csr_write_enable,
   input  wire logic [pmcc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pmcc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  wire logic [pmcc_pkg::NODE_W-1:0]         req_node_index,
   input  wire logic [pmcc_pkg::ARC_W-1:0]          req_arc_index,
   input  wire logic [pmcc_pkg::NODE_W-1:0]         req_neighbor_node,
   input  wire logic [pmcc_pkg::ARC_W-1:0]          req_neighbor_arc,
   output logic                                     rsp_valid,
   output logic [pmcc_pkg::NODE_W-1:0]              rsp_row_index,
   output logic [pmcc_pkg::NODE_W-1:0]              rsp_nbr0,
   output logic [pmcc_pkg::NODE_W-1:0]              rsp_nbr1,
   output logic [pmcc_pkg::NODE_W-1:0]              rsp_nbr2,
   output logic [pmcc_pkg::NODE_W-1:0]              rsp_nbr3,
   output logic                                     rsp_first_omitted,
   output logic                                     rsp_last
);

   localparam int NW   = pmcc_pkg::NODE_W;
   localparam int AW   = pmcc_pkg::ARC_W;
   localparam int ENT  = MAX_NODES * pmcc_pkg::ARCS;
   localparam int NAW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int EAW  = $clog2(ENT);
   localparam logic [NW-1:0] MAX_N = NW'(MAX_NODES);

   // configuration
   logic          use_refl_ff, tight_ff;
   logic [NW-1:0] node_count_ff;
   logic [NW-1:0] n_eff, n_last;

   // search counters and try state
   logic          refl_ff;
   logic [NW-1:0] start_ff, lab_ff, next_label_ff, src_ff, nb_ff;
   logic [AW-1:0] off0_ff, arc_ff, off_ff, na_ff;
   logic          better_ff, best_valid_ff;
   logic [MAX_NODES-1:0] mapped_ff;

   // memories and read data
   logic [2*NW-1:0] unused_pad;
   logic [NW+AW-1:0] adj_mem [ENT];
   logic [NW-1:0]    lab_mem [MAX_NODES];
   logic [NW-1:0]    pre_mem [MAX_NODES];
   logic [AW-1:0]    offs_mem [MAX_NODES];
   logic [NW-1:0]    best_mem [ENT];
   logic [NW+AW-1:0] adj_rd_ff;
   logic [NW-1:0]    lab_rd_ff, pre_rd_ff, best_rd_ff;
   logic [AW-1:0]    offs_rd_ff;

   // output capture
   logic          rd_en_ff;
   logic [AW-1:0] rd_arc_ff;
   logic [NW-1:0] nbr_ff [pmcc_pkg::ARCS];
   logic          rsp_valid_ff, rsp_last_ff;
   logic [NW-1:0] rsp_row_ff;

   // combinational
   logic [NW-1:0]  src_c, nb_raw, nb_c, label_c, cand_c;
   logic [AW-1:0]  idx_c;
   logic [EAW-1:0] ent_addr, adj_rd_addr, adj_wr_addr;
   logic           is_mapped, do_map, better_now, worse_c;

   assign unused_pad = '0;

   // clamp node count into 1..MAX_NODES
   always_comb begin
      priority if (node_count_ff == '0) begin
         n_eff = NW'(1);
      end else if (node_count_ff > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = node_count_ff;
      end
   end
   assign n_last = n_eff - NW'(1);

   assign ent_addr    = EAW'({lab_ff, arc_ff});
   assign idx_c       = refl_ff ? (AW'(0) - off_ff - arc_ff) : (arc_ff - off_ff);
   assign adj_rd_addr = EAW'({src_ff, idx_c});
   assign adj_wr_addr = EAW'({req_node_index, req_arc_index});

   // source node of the label being expanded
   assign src_c = (lab_ff < next_label_ff && pre_rd_ff < n_eff) ? pre_rd_ff : '0;

   // neighbor node, clamped into the graph
   assign nb_raw = adj_rd_ff[NW+AW-1:AW];
   assign nb_c   = (nb_raw >= n_eff) ? n_last : nb_raw;

   // label of the neighbor and the candidate code symbol
   assign is_mapped = mapped_ff[NAW'(nb_ff)];
   assign do_map    = !is_mapped && (next_label_ff < MAX_N);
   always_comb begin
      priority if (is_mapped) begin
         label_c = lab_rd_ff;
      end else if (do_map) begin
         label_c = next_label_ff;
      end else begin
         label_c = '0;
      end
   end
   assign cand_c     = (tight_ff && arc_ff == '0) ? '0 : label_c;
   assign better_now = better_ff || (cand_c < best_rd_ff);
   assign worse_c    = !better_ff && (cand_c > best_rd_ff);

   assign status.worse       = worse_c;
   assign status.arc_last    = (arc_ff == AW'(pmcc_pkg::ARCS - 1));
   assign status.lab_last    = (lab_ff == n_last);
   assign status.search_done = (off0_ff == AW'(pmcc_pkg::ARCS - 1)) &&
                               (start_ff == n_last) && (refl_ff || !use_refl_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         use_refl_ff   <= 1'b0;
         tight_ff      <= 1'b0;
         node_count_ff <= NW'(1);
      end else if (csr_write_enable) begin
         priority case (csr_index)
            pmcc_pkg::CSR_USE_REFLECTION: use_refl_ff   <= csr_write_data[0];
            pmcc_pkg::CSR_TIGHT_MODE:     tight_ff      <= csr_write_data[0];
            pmcc_pkg::CSR_NODE_COUNT:     node_count_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // adjacency table
   always_ff @(posedge clock) begin
      if (cmd.load_wr && req_node_index < MAX_N) begin
         adj_mem[adj_wr_addr] <= {req_neighbor_node, req_neighbor_arc};
      end
      if (cmd.adj_rd) begin
         adj_rd_ff <= adj_mem[adj_rd_addr];
      end
   end

   // image label table
   always_ff @(posedge clock) begin
      if (cmd.try_init) begin
         lab_mem[NAW'(start_ff)] <= '0;
      end else if (cmd.cmp_step && do_map) begin
         lab_mem[NAW'(nb_ff)] <= next_label_ff;
      end
      if (cmd.nb_step) begin
         lab_rd_ff <= lab_mem[NAW'(nb_c)];
      end
   end

   // preimage table
   always_ff @(posedge clock) begin
      if (cmd.try_init) begin
         pre_mem[0] <= start_ff;
      end else if (cmd.cmp_step && do_map) begin
         pre_mem[NAW'(next_label_ff)] <= nb_ff;
      end
      if (cmd.pre_rd) begin
         pre_rd_ff <= pre_mem[NAW'(lab_ff)];
      end
   end

   // arc offset table
   always_ff @(posedge clock) begin
      if (cmd.try_init) begin
         offs_mem[NAW'(start_ff)] <= AW'(0) - off0_ff;
      end else if (cmd.cmp_step && do_map) begin
         offs_mem[NAW'(nb_ff)] <= AW'(0) - na_ff;
      end
      if (cmd.src_sel) begin
         offs_rd_ff <= offs_mem[NAW'(src_c)];
      end
   end

   // best code table
   always_ff @(posedge clock) begin
      if (cmd.cmp_step && better_now) begin
         best_mem[ent_addr] <= cand_c;
      end
      if (cmd.nb_step || cmd.out_rd) begin
         best_rd_ff <= best_mem[ent_addr];
      end
   end

   // search counters and try bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
         better_ff     <= 1'b0;
         next_label_ff <= NW'(1);
         refl_ff       <= 1'b0;
         start_ff      <= '0;
         off0_ff       <= '0;
         lab_ff        <= '0;
         arc_ff        <= '0;
         mapped_ff     <= '0;
      end else begin
         if (cmd.run_start) begin
            best_valid_ff <= 1'b0;
            refl_ff       <= 1'b0;
            start_ff      <= '0;
            off0_ff       <= '0;
         end
         if (cmd.try_init) begin
            // only the start node is mapped at the beginning of a try
            mapped_ff     <= MAX_NODES'(1) << NAW'(start_ff);
            next_label_ff <= NW'(1);
            better_ff     <= !best_valid_ff;
            lab_ff        <= '0;
            arc_ff        <= '0;
         end
         if (cmd.cmp_step) begin
            better_ff <= better_now;
            if (do_map) begin
               mapped_ff[NAW'(nb_ff)] <= 1'b1;
               next_label_ff <= next_label_ff + NW'(1);
            end
            arc_ff <= arc_ff + AW'(1);
            if (arc_ff == AW'(pmcc_pkg::ARCS - 1)) begin
               lab_ff <= lab_ff + NW'(1);
            end
         end
         if (cmd.try_end) begin
            if (better_ff) begin
               best_valid_ff <= 1'b1;
            end
            off0_ff <= off0_ff + AW'(1);
            if (off0_ff == AW'(pmcc_pkg::ARCS - 1)) begin
               if (start_ff == n_last) begin
                  start_ff <= '0;
                  refl_ff  <= 1'b1;
               end else begin
                  start_ff <= start_ff + NW'(1);
               end
            end
            lab_ff <= '0;
            arc_ff <= '0;
         end
         if (cmd.out_rd) begin
            arc_ff <= arc_ff + AW'(1);
         end
         if (cmd.row_next) begin
            lab_ff <= lab_ff + NW'(1);
         end
      end
   end

   // source node and its arc offset
   always_ff @(posedge clock) begin
      if (cmd.src_sel) begin
         src_ff <= src_c;
      end
      if (cmd.off_load) begin
         off_ff <= mapped_ff[NAW'(src_ff)] ? offs_rd_ff : '0;
      end else if (cmd.cmp_step && do_map && nb_ff == src_ff) begin
         off_ff <= AW'(0) - na_ff;
      end
      if (cmd.nb_step) begin
         nb_ff <= nb_c;
         na_ff <= adj_rd_ff[AW-1:0];
      end
   end

   // gather one output row
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_en_ff <= cmd.out_rd;
         if (cmd.rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (cmd.rsp_clr) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_arc_ff <= arc_ff;
      if (rd_en_ff) begin
         nbr_ff[rd_arc_ff] <= best_rd_ff;
      end
      if (cmd.rsp_set) begin
         rsp_row_ff  <= lab_ff;
         rsp_last_ff <= (lab_ff == n_last);
      end
   end

   assign rsp_valid         = rsp_valid_ff | (|unused_pad);
   assign rsp_row_index     = rsp_row_ff;
   assign rsp_nbr0          = nbr_ff[0];
   assign rsp_nbr1          = nbr_ff[1];
   assign rsp_nbr2          = nbr_ff[2];
   assign rsp_nbr3          = nbr_ff[3];
   assign rsp_first_omitted = tight_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/planar_map_canonical_code_core.sv */
// Top level of the planar map canonical code core
//
// Usage:
//  - Requests come on req_* with valid/stall. A load request (kind 0) writes one
//    adjacency entry and yields no result; the next request may follow on the
//    next cycle.
//  - A run request (kind 1) searches every start node and start arc, plus mirror
//    orientations when use_reflection is set. Each try stops early once it loses
//    to the best code. The search walks the label and code tables one arc at a
//    time.
//  - Then N rows come on rsp_* in label order; the last row carries rsp_last.
//    While a run or its rows are pending, req_stall is high.
//  - A stalled row holds its value until taken.
//  - csr_* writes use_reflection, tight_mode and node_count; write only when idle.
//  - Reset clears the controller and the configuration (node_count becomes 1);
//    the adjacency table holds no defined value until loaded.
`default_nettype none

module planar_map_canonical_code_core #(
   parameter int MAX_NODES = 52
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_kind,
   input  wire logic [pmcc_pkg::NODE_W-1:0]     req_node_index,
   input  wire logic [pmcc_pkg::ARC_W-1:0]      req_arc_index,
   input  wire logic [pmcc_pkg::NODE_W-1:0]     req_neighbor_node,
   input  wire logic [pmcc_pkg::ARC_W-1:0]      req_neighbor_arc,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [pmcc_pkg::NODE_W-1:0]          rsp_row_index,
   output logic [pmcc_pkg::NODE_W-1:0]          rsp_nbr0,
   output logic [pmcc_pkg::NODE_W-1:0]          rsp_nbr1,
   output logic [pmcc_pkg::NODE_W-1:0]          rsp_nbr2,
   output logic [pmcc_pkg::NODE_W-1:0]          rsp_nbr3,
   output logic                                 rsp_first_omitted,
   output logic                                 rsp_last,
   input  wire logic                            csr_write_enable,
   input  wire logic [pmcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pmcc_pkg::CSR_DATA_W-1:0] csr_write_data
);

   pmcc_pkg::cmd_type    cmd;
   pmcc_pkg::status_type status;

   pmcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   pmcc_dp #(
      .MAX_NODES (MAX_NODES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_node_index    (req_node_index),
      .req_arc_index     (req_arc_index),
      .req_neighbor_node (req_neighbor_node),
      .req_neighbor_arc  (req_neighbor_arc),
      .rsp_valid         (rsp_valid),
      .rsp_row_index     (rsp_row_index),
      .rsp_nbr0          (rsp_nbr0),
      .rsp_nbr1          (rsp_nbr1),
      .rsp_nbr2          (rsp_nbr2),
      .rsp_nbr3          (rsp_nbr3),
      .rsp_first_omitted (rsp_first_omitted),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

/* hw/rtl/pmcc_checker.sv */
// Port-level checker of the canonical code core and its bind
`default_nettype none
`include "planar_map_canonical_code_core_assert.svh"

module pmcc_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [pmcc_pkg::NODE_W-1:0] rsp_row_index,
   input wire logic [pmcc_pkg::NODE_W-1:0] rsp_nbr0,
   input wire logic                        rsp_first_omitted,
   input wire logic                        rsp_last
);

   // hold a stalled row
   `PMCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_row_index))

   // requests wait while rows are out
   `PMCC_ASSERT_SAME(a_busy_rows, clock, reset, rsp_valid, req_stall)

   // more rows pending keeps the block busy
   `PMCC_ASSERT_NEXT(a_busy_more, clock, reset, rsp_valid && !rsp_stall && !rsp_last, req_stall)

   // tight mode drops arc zero
   `PMCC_ASSERT_SAME(a_tight_zero, clock, reset, rsp_valid && rsp_first_omitted, rsp_nbr0 == '0)

endmodule

bind planar_map_canonical_code_core pmcc_checker u_pmcc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_row_index     (rsp_row_index),
   .rsp_nbr0          (rsp_nbr0),
   .rsp_first_omitted (rsp_first_omitted),
   .rsp_last          (rsp_last)
);

`default_nettype wire
